FILE: rtl/gtbp_pkg.sv
package gtbp_pkg;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_LOCAL,
		ST_UPDATE
	} gtbp_state_t;

	typedef logic [1:0] ctr_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GHIST_W   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LHIST_W   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PC_IDX_W  = 2'd3;

	localparam logic [1:0] MODE_STATIC = 2'd0;
	localparam logic [1:0] MODE_GSHARE = 2'd1;
	localparam logic [1:0] MODE_TOURN  = 2'd2;

	localparam logic [1:0] MODE_RST    = MODE_GSHARE;
	localparam logic [3:0] GHIST_W_RST = 4'd13;
	localparam logic [3:0] LHIST_W_RST = 4'd10;
	localparam logic [3:0] PC_IDX_RST  = 4'd10;

	localparam ctr_t CTR_RST = 2'd1;
	localparam ctr_t CTR_MAX = 2'd3;
	localparam ctr_t CTR_MIN = 2'd0;

	function automatic ctr_t ctr_train(ctr_t c, logic up);
		ctr_t r;
		if (up) begin
			r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
		end else begin
			r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
		end
		return r;
	endfunction

endpackage

FILE: rtl/gtbp_ram.sv
module gtbp_ram #(
	parameter int AW = 13,
	parameter int DW = 2
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/gshare_tournament_branch_predictor.sv
// Sequence: the edge that accepts start moves the FSM to ST_LOOKUP, then ST_LOCAL, then
// ST_UPDATE; done is registered from ST_UPDATE. A new branch is accepted only while busy is low,
// which it is again in the cycle done is high. The dependent reads set the states: the local
// history read feeds the local counter read, each a synchronous memory access, then write-back.
// Reset: a clearing pass writes all 2**TABLE_INDEX_BITS entries (8192 by default) of the
// tables with busy high; config writes are taken meanwhile. done cannot be held off.
module gshare_tournament_branch_predictor #(
	parameter int TABLE_INDEX_BITS = 13
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gtbp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [gtbp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                               start,
	output logic                               busy,
	input  logic [31:0]                        branch_pc,
	input  logic                               was_taken,
	output logic                               done,
	output logic                               predicted_taken,
	output logic                               global_guess,
	output logic                               local_guess,
	output logic                               chose_local
);

	import gtbp_pkg::*;

	localparam int TIB = TABLE_INDEX_BITS;

	function automatic logic [TIB-1:0] width_mask(logic [3:0] bits);
		logic [TIB-1:0] m;
		for (int i = 0; i < TIB; i++) begin
			m[i] = (5'(i) < {1'b0, bits});
		end
		return m;
	endfunction

	gtbp_state_t state_q, state_d;

	logic [1:0]     mode_q;
	logic [3:0]     ghist_w_q, lhist_w_q, pc_idx_w_q;
	logic [TIB-1:0] hist_q;
	logic [TIB-1:0] clr_q;

	logic [TIB-1:0] item_pc_q;
	logic           item_taken_q;
	logic [1:0]     item_mode_q;

	logic [TIB-1:0] gmask, lmask, pmask, pc_lo;
	logic [TIB-1:0] pidx, gidx, sidx, lidx;
	logic           is_gs, is_tour, active, clearing, upd;

	ctr_t           gc_rd, lc_rd, ch_rd;
	logic [TIB-1:0] lh_rd;
	ctr_t           gc_wd, lc_wd, ch_wd;
	logic [TIB-1:0] lh_wd;
	logic           gc_we, tour_we;
	logic           l_ok, g_ok;
	ctr_t           ch_new;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RST;
			ghist_w_q  <= GHIST_W_RST;
			lhist_w_q  <= LHIST_W_RST;
			pc_idx_w_q <= PC_IDX_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MODE:     mode_q     <= cfg_wdata[1:0];
				REG_GHIST_W:  ghist_w_q  <= cfg_wdata;
				REG_LHIST_W:  lhist_w_q  <= cfg_wdata;
				REG_PC_IDX_W: pc_idx_w_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:  if (&clr_q) state_d = ST_IDLE;
			ST_IDLE:   if (start) state_d = ST_LOOKUP;
			ST_LOOKUP: state_d = ST_LOCAL;
			ST_LOCAL:  state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	assign busy     = (state_q != ST_IDLE);
	assign clearing = (state_q == ST_CLEAR);
	assign upd      = (state_q == ST_UPDATE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// capture the branch at transfer
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_pc_q    <= branch_pc[TIB-1:0];
			item_taken_q <= was_taken;
			item_mode_q  <= mode_q;
		end
	end

	assign gmask   = width_mask(ghist_w_q);
	assign lmask   = width_mask(lhist_w_q);
	assign pmask   = width_mask(pc_idx_w_q);
	assign pc_lo   = item_pc_q;
	assign is_gs   = (item_mode_q == MODE_GSHARE);
	assign is_tour = (item_mode_q == MODE_TOURN);
	assign active  = is_gs || is_tour;

	assign pidx = is_gs ? (pc_lo & gmask) : (pc_lo & pmask);
	assign gidx = (pidx ^ hist_q) & gmask;
	assign sidx = pc_lo & gmask;
	assign lidx = lh_rd & lmask;

	// training
	assign l_ok = (lc_rd[1] == item_taken_q);
	assign g_ok = (gc_rd[1] == item_taken_q);

	always_comb begin
		ch_new = ch_rd;
		if (l_ok && !g_ok) begin
			ch_new = ctr_train(ch_rd, 1'b1);
		end else if (!l_ok && g_ok) begin
			ch_new = ctr_train(ch_rd, 1'b0);
		end
	end

	assign gc_we   = clearing || (upd && active);
	assign tour_we = clearing || (upd && is_tour);
	assign gc_wd   = clearing ? CTR_RST : ctr_train(gc_rd, item_taken_q);
	assign lc_wd   = clearing ? CTR_RST : ctr_train(lc_rd, item_taken_q);
	assign ch_wd   = clearing ? CTR_RST : ch_new;
	assign lh_wd   = clearing ? '0 : {lh_rd[TIB-2:0], item_taken_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
		end else if (upd && active) begin
			hist_q <= ({hist_q[TIB-2:0], 1'b0} & gmask) | {{(TIB-1){1'b0}}, item_taken_q};
		end
	end

	gtbp_ram #(.AW(TIB), .DW(2)) u_gc (
		.clk   (clk),
		.we    (gc_we),
		.waddr (clearing ? clr_q : gidx),
		.wdata (gc_wd),
		.re    (state_q == ST_LOOKUP),
		.raddr (gidx),
		.rdata (gc_rd)
	);

	gtbp_ram #(.AW(TIB), .DW(TIB)) u_lh (
		.clk   (clk),
		.we    (tour_we),
		.waddr (clearing ? clr_q : pidx),
		.wdata (lh_wd),
		.re    (state_q == ST_LOOKUP),
		.raddr (pidx),
		.rdata (lh_rd)
	);

	gtbp_ram #(.AW(TIB), .DW(2)) u_ch (
		.clk   (clk),
		.we    (tour_we),
		.waddr (clearing ? clr_q : sidx),
		.wdata (ch_wd),
		.re    (state_q == ST_LOOKUP),
		.raddr (sidx),
		.rdata (ch_rd)
	);

	// local counter index comes from the local history just read
	gtbp_ram #(.AW(TIB), .DW(2)) u_lc (
		.clk   (clk),
		.we    (tour_we),
		.waddr (clearing ? clr_q : lidx),
		.wdata (lc_wd),
		.re    (state_q == ST_LOCAL),
		.raddr (lidx),
		.rdata (lc_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (upd) begin
			predicted_taken <= !active || ((is_tour && ch_rd[1]) ? lc_rd[1] : gc_rd[1]);
			global_guess    <= active && gc_rd[1];
			local_guess     <= is_tour && lc_rd[1];
			chose_local     <= is_tour && ch_rd[1];
		end
	end

`ifndef NO_ASSERTIONS
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without write-back");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		gc_we |-> (state_q == ST_CLEAR || state_q == ST_UPDATE))
		else $error("table write outside clear or write-back");

	a_local_only_tourn: assert property (@(posedge clk) disable iff (!arst_n)
		(done && item_mode_q != MODE_TOURN) |-> (!local_guess && !chose_local))
		else $error("local side reported outside tournament mode");

	a_choice_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(done && chose_local) |-> (predicted_taken == local_guess))
		else $error("prediction does not follow chosen local guess");
`endif

endmodule

FILE: dv/gshare_tournament_branch_predictor_tb.sv
module gshare_tournament_branch_predictor_tb;
	import gtbp_pkg::*;

	localparam int TBL_BITS = 13;
	localparam int TBL_DEPTH = 1 << TBL_BITS;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		logic predicted_taken;
		logic global_guess;
		logic local_guess;
		logic chose_local;
	} guess_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  start     = 1'b0;
	logic                  busy;
	logic [31:0]           branch_pc = '0;
	logic                  was_taken = 1'b0;
	logic                  done;
	logic                  predicted_taken;
	logic                  global_guess;
	logic                  local_guess;
	logic                  chose_local;

	// predictor copy: configuration, histories and counter tables
	logic [1:0]  cur_mode;
	logic [3:0]  ghist_w;
	logic [3:0]  lhist_w;
	logic [3:0]  pcidx_w;
	logic [12:0] global_hist;
	ctr_t        gctr    [TBL_DEPTH];
	logic [12:0] lhist   [TBL_DEPTH];
	ctr_t        lctr    [TBL_DEPTH];
	ctr_t        chooser [TBL_DEPTH];

	guess_t pending_guesses[$];
	int     errors   = 0;
	int     idle_pct = 0;

	logic [31:0] hot_pc     [8];
	int          hot_period [8];
	int          hot_count  [8];

	gshare_tournament_branch_predictor #(.TABLE_INDEX_BITS(TBL_BITS)) dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_idx         (cfg_idx),
		.cfg_wdata       (cfg_wdata),
		.start           (start),
		.busy            (busy),
		.branch_pc       (branch_pc),
		.was_taken       (was_taken),
		.done            (done),
		.predicted_taken (predicted_taken),
		.global_guess    (global_guess),
		.local_guess     (local_guess),
		.chose_local     (chose_local)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [12:0] width_mask(logic [3:0] w);
		int b;
		b = (w > TBL_BITS) ? TBL_BITS : int'(w);
		return 13'((32'd1 << b) - 32'd1);
	endfunction

	function automatic ctr_t bump(ctr_t c, logic up);
		if (up) begin
			return (c == CTR_MAX) ? c : c + 2'd1;
		end
		return (c == CTR_MIN) ? c : c - 2'd1;
	endfunction

	function automatic void reset_model();
		cur_mode = MODE_RST;
		ghist_w = GHIST_W_RST;
		lhist_w = LHIST_W_RST;
		pcidx_w = PC_IDX_RST;
		global_hist = '0;
		for (int i = 0; i < TBL_DEPTH; i++) begin
			gctr[i] = CTR_RST;
			lhist[i] = '0;
			lctr[i] = CTR_RST;
			chooser[i] = CTR_RST;
		end
	endfunction

	// report the guess from current state, then train on the outcome in gshare and tournament modes
	function automatic guess_t predict_and_train(logic [31:0] pc, logic tk);
		guess_t g;
		logic [12:0] gm, lm, pm, hist, pidx, gidx, lidx, sidx;
		logic gg, lg, pick, l_ok, g_ok;
		ctr_t ch;
		g = '0;
		if (cur_mode != MODE_GSHARE && cur_mode != MODE_TOURN) begin
			g.predicted_taken = 1'b1;
			return g;
		end
		gm = width_mask(ghist_w);
		lm = width_mask(lhist_w);
		pm = width_mask(pcidx_w);
		hist = global_hist & gm;
		pidx = (cur_mode == MODE_GSHARE) ? (pc[12:0] & gm) : (pc[12:0] & pm);
		gidx = (pidx ^ hist) & gm;
		gg = gctr[gidx][1];
		g.global_guess = gg;
		g.predicted_taken = gg;
		if (cur_mode == MODE_TOURN) begin
			lidx = lhist[pidx] & lm;
			sidx = pc[12:0] & gm;
			ch = chooser[sidx];
			lg = lctr[lidx][1];
			pick = ch[1];
			g.local_guess = lg;
			g.chose_local = pick;
			g.predicted_taken = pick ? lg : gg;
			l_ok = (lg == tk);
			g_ok = (gg == tk);
			if (l_ok && !g_ok) begin
				chooser[sidx] = bump(ch, 1'b1);
			end else if (!l_ok && g_ok) begin
				chooser[sidx] = bump(ch, 1'b0);
			end
			lctr[lidx] = bump(lctr[lidx], tk);
			lhist[pidx] = {lhist[pidx][11:0], tk};
		end
		gctr[gidx] = bump(gctr[gidx], tk);
		global_hist = ({global_hist[11:0], 1'b0} & gm) | {12'd0, tk};
		return g;
	endfunction

	function automatic logic [3:0] pick_width();
		int r;
		r = $urandom_range(9);
		if (r == 0) begin
			return 4'd0;
		end else if (r == 1) begin
			return 4'd13;
		end else if (r == 2) begin
			return 4'($urandom_range(15, 14));
		end
		return 4'($urandom_range(12, 1));
	endfunction

	function automatic void check_field(string name, logic want, logic got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s expected %0b got %0b", $time, name, want, got);
		end
	endfunction

	// keep start high across back-to-back transfers; drop it only for a gap
	task automatic send_branch(logic [31:0] pc, logic tk);
		start <= 1'b1;
		branch_pc <= pc;
		was_taken <= tk;
		do @(posedge clk); while (busy);
		pending_guesses.push_back(predict_and_train(pc, tk));
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(15, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		while (pending_guesses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [3:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		case (idx)
			REG_MODE:     cur_mode = val[1:0];
			REG_GHIST_W:  ghist_w = val;
			REG_LHIST_W:  lhist_w = val;
			REG_PC_IDX_W: pcidx_w = val;
			default: ;
		endcase
	endtask

	task automatic configure(logic [3:0] m, logic [3:0] g, logic [3:0] l, logic [3:0] p);
		wait_idle();
		write_reg(REG_MODE, m);
		write_reg(REG_GHIST_W, g);
		write_reg(REG_LHIST_W, l);
		write_reg(REG_PC_IDX_W, p);
		cfg_we <= 1'b0;
	endtask

	// mostly loop-like branches on a few hot PCs, the rest random noise
	task automatic run_branch_mix(int n);
		int k;
		for (int i = 0; i < 8; i++) begin
			hot_pc[i] = $urandom;
			hot_period[i] = $urandom_range(6, 1);
			hot_count[i] = 0;
		end
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 7) begin
				k = $urandom_range(7);
				send_branch(hot_pc[k], (hot_count[k] % hot_period[k]) != hot_period[k] - 1);
				hot_count[k]++;
			end else begin
				send_branch($urandom, 1'($urandom_range(1)));
			end
		end
	endtask

	task automatic test_reset_defaults();
		send_branch(32'h0000_0100, 1'b1);
		send_branch(32'h0000_0100, 1'b1);
	endtask

	task automatic test_static_modes();
		configure({2'b00, MODE_STATIC}, GHIST_W_RST, LHIST_W_RST, PC_IDX_RST);
		send_branch(32'h0000_0000, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b0);
		configure({2'b00, MODE_SPARE}, GHIST_W_RST, LHIST_W_RST, PC_IDX_RST);
		send_branch(32'h1234_5678, 1'b0);
	endtask

	task automatic test_gshare_widths();
		configure({2'b00, MODE_GSHARE}, 4'd13, 4'd10, 4'd10);
		send_branch(32'h0000_0000, 1'b1);
		send_branch(32'h0000_0000, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b1);
		send_branch(32'hAAAA_AAAA, 1'b0);
		configure({2'b00, MODE_GSHARE}, 4'd0, 4'd10, 4'd10);
		send_branch(32'h5555_5555, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b0);
		configure({2'b00, MODE_GSHARE}, 4'd15, 4'd10, 4'd10);
		send_branch(32'hFFFF_FFFF, 1'b1);
		send_branch(32'h8000_1FFF, 1'b0);
	endtask

	task automatic test_tournament_widths();
		configure({2'b00, MODE_TOURN}, 4'd13, 4'd10, 4'd10);
		for (int i = 0; i < 4; i++) begin
			send_branch(32'h0000_0040, 1'(i % 2));
		end
		configure({2'b11, MODE_TOURN}, 4'd1, 4'd0, 4'd15);
		send_branch(32'hFFFF_FFFF, 1'b1);
		send_branch(32'hFFFF_FFFF, 1'b0);
		send_branch(32'h0000_0000, 1'b1);
		configure({2'b00, MODE_TOURN}, 4'd15, 4'd15, 4'd0);
		send_branch(32'hFFFF_FFFF, 1'b0);
		send_branch(32'h0000_1FFF, 1'b1);
		send_branch(32'hAAAA_AAAA, 1'b1);
	endtask

	task automatic test_pause_until_empty();
		configure({2'b00, MODE_TOURN}, 4'd6, 4'd4, 4'd5);
		run_branch_mix(20);
		wait_idle();
		run_branch_mix(20);
	endtask

	task automatic test_random_configs();
		logic [1:0] m;
		int r;
		for (int ph = 0; ph < 8; ph++) begin
			r = $urandom_range(9);
			m = (r < 4) ? MODE_TOURN : (r < 7) ? MODE_GSHARE : (r < 8) ? MODE_STATIC :
				(r < 9) ? MODE_SPARE : 2'($urandom_range(3));
			if (ph == 0) begin
				configure({2'b00, MODE_TOURN}, 4'd13, 4'd13, 4'd13);
			end else if (ph == 1) begin
				configure({2'b00, MODE_TOURN}, 4'd1, 4'd1, 4'd1);
			end else begin
				configure({2'($urandom_range(3)), m}, pick_width(), pick_width(), pick_width());
			end
			idle_pct = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 5);
			run_branch_mix(95);
		end
	endtask

	task automatic test_back_to_back_tail();
		idle_pct = 0;
		configure({2'b00, MODE_TOURN}, pick_width(), pick_width(), pick_width());
		run_branch_mix(60);
	endtask

	always @(posedge clk) begin : check_result
		guess_t want;
		if (arst_n && done) begin
			if (pending_guesses.size() == 0) begin
				errors++;
				$display("%0t: result with no branch outstanding", $time);
			end else begin
				want = pending_guesses.pop_front();
				check_field("predicted_taken", want.predicted_taken, predicted_taken);
				check_field("global_guess", want.global_guess, global_guess);
				check_field("local_guess", want.local_guess, local_guess);
				check_field("chose_local", want.chose_local, chose_local);
			end
		end
	end

	initial begin
		reset_model();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		idle_pct = 30;
		test_reset_defaults();
		test_static_modes();
		test_gshare_widths();
		test_tournament_widths();
		test_pause_until_empty();
		test_random_configs();
		test_back_to_back_tail();
		wait_idle();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
rtl/gtbp_pkg.sv
rtl/gtbp_ram.sv
rtl/gshare_tournament_branch_predictor.sv
dv/gshare_tournament_branch_predictor_tb.sv
